FILE: hdl/lbs_pkg.sv
// Package for the four-bone skinning block: fixed sizes, queue entry type,
// sequencer state encoding and a 32-bit saturation helper. No dependencies.
`timescale 1ns / 1ps
package lbs_pkg;
	localparam int WordsPerBone = 12;
	localparam int Influences = 4;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef struct packed {
		logic                op;
		logic [9:0]          entry_addr;
		logic signed [31:0]  entry_value;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  pos_z;
		logic signed [31:0]  nrm_x;
		logic signed [31:0]  nrm_y;
		logic signed [31:0]  nrm_z;
		logic [31:0]         bone_ids;
		logic [63:0]         bone_weights;
		logic [3:0]          active;
		logic                last_vertex;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_LOAD  = 5'b10000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -49'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage

FILE: hdl/lbs_front.sv
// Front end: accepts items, marks live influences, queues them in a short
// FIFO for the back end. Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_front #(
	parameter int MAX_BONES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  lbs_pkg::item_t     in_item,
	output logic               q_valid,
	input  logic               q_pop,
	output lbs_pkg::item_t     q_item
);
	import lbs_pkg::*;

	localparam int Depth = 2;

	logic [6:0] bone_count_q;
	item_t      fifo_q [Depth];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [8:0] limit;
	logic [3:0] act;
	logic       push;
	item_t      cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bone_count_q <= '0;
		else if (cfg_we) bone_count_q <= cfg_wdata;
	end

	always_comb begin
		limit = ({2'b0, bone_count_q} < 9'(MAX_BONES)) ? {2'b0, bone_count_q} : 9'(MAX_BONES);
		for (int i = 0; i < Influences; i++)
			act[i] = (in_item.bone_weights[16*i +: 16] != 16'd0) &&
				({1'b0, in_item.bone_ids[8*i +: 8]} < limit);
		cls = in_item;
		cls.active = act;
	end

	assign in_stall = (count_q == 2'(Depth));
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

FILE: hdl/lbs_back.sv
// Back end: palette memory, one shared multiplier sequenced over the
// matrix words, weighting and accumulation, output register. Uses lbs_pkg.
`timescale 1ns / 1ps
module lbs_back #(
	parameter int MAX_BONES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  lbs_pkg::item_t     q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_q [6],
	output logic               mesh_end_q
);
	import lbs_pkg::*;

	localparam int Words = MAX_BONES * WordsPerBone;
	localparam int AW = $clog2(Words);

	// Work list: per influence, 18 products (6 outputs x 3 rows) then 3 translation
	// reads, then 6 weighting multiplies. Step counter walks it.
	logic [31:0] pal_mem [Words];
	logic signed [31:0] rd_data_q;
	state_t state_q;
	logic [1:0] inf_q;
	logic [5:0] step_q;
	logic signed [48:0] xacc_q [6];
	logic signed [31:0] xsat_q [6];
	logic signed [48:0] wacc_q [6];
	logic signed [63:0] prod_s1;
	logic       pv_s1;
	logic [5:0] pstep_s1;
	logic       out_valid_q;

	// step 0..17: transform products (comp c = step/3, row r = step%3)
	// step 18..20: translation for position comp; 21..26 weight multiplies
	localparam logic [5:0] StepXEnd = 6'd21;
	localparam logic [5:0] StepEnd = 6'd27;

	logic [7:0]  bone;
	logic [2:0]  comp;
	logic [1:0]  row;
	logic [1:0]  col;
	logic [AW-1:0] raddr;
	logic signed [31:0] vin;
	logic signed [31:0] mop_a, mop_b;
	logic [15:0] weight;

	// step / 3 for steps below 18, by reciprocal multiply (11/32)
	function automatic logic [2:0] comp_of(input logic [5:0] s);
		logic [9:0] m;
		m = 10'(s) * 10'd11;
		return m[7:5];
	endfunction

	assign bone = q_item.bone_ids[8*inf_q +: 8];
	assign weight = q_item.bone_weights[16*inf_q +: 16];

	always_comb begin
		comp = 3'd0;
		row = 2'd0;
		if (step_q < 6'd18) begin
			comp = comp_of(step_q);
			row = 2'(step_q - 6'(comp) * 6'd3);
		end else if (step_q < StepXEnd) begin
			comp = 3'(step_q - 6'd18);
			row = 2'd3;
		end
		col = (comp < 3'd3) ? 2'(comp) : 2'(comp - 3'd3);
		raddr = AW'(bone * WordsPerBone + row * 3 + col);
		unique case (row)
			2'd0: vin = (comp < 3'd3) ? q_item.pos_x : q_item.nrm_x;
			2'd1: vin = (comp < 3'd3) ? q_item.pos_y : q_item.nrm_y;
			default: vin = (comp < 3'd3) ? q_item.pos_z : q_item.nrm_z;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && {22'd0, q_item.entry_addr} < 32'(Words))
			pal_mem[AW'(q_item.entry_addr)] <= q_item.entry_value;
		rd_data_q <= pal_mem[raddr];
	end

	// Stage s1 multiply: operands are the registered palette word and vertex
	// component of the previous step, or a saturated transform and the weight.
	logic       rv_q;
	logic [5:0] rstep_q;
	logic signed [31:0] rvin_q;
	logic [15:0] rweight_q;
	always_comb begin
		if (rstep_q >= StepXEnd) begin
			mop_a = xsat_q[3'(rstep_q - StepXEnd)];
			mop_b = {16'd0, rweight_q};
		end else begin
			mop_a = rvin_q;
			mop_b = rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inf_q <= '0;
			step_q <= '0;
			rv_q <= 1'b0;
			pv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			pv_s1 <= rv_q;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && !out_valid_q) begin
						if (q_item.op == OP_LOAD) state_q <= ST_LOAD;
						else begin
							state_q <= ST_RUN;
							inf_q <= '0;
							step_q <= '0;
						end
					end else if (q_valid && q_item.op == OP_LOAD) state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_RUN: begin
					if (!q_item.active[inf_q]) begin
						if (inf_q == 2'(Influences - 1)) state_q <= ST_DRAIN;
						else inf_q <= inf_q + 2'd1;
					end else if (step_q == StepXEnd && (rv_q || pv_s1)) begin
						// wait for the last translation to settle in xsat
					end else begin
						rv_q <= 1'b1;
						if (step_q == StepEnd - 6'd1) begin
							step_q <= '0;
							if (inf_q == 2'(Influences - 1)) state_q <= ST_DRAIN;
							else inf_q <= inf_q + 2'd1;
						end else step_q <= step_q + 6'd1;
					end
				end
				ST_DRAIN: if (!rv_q && !pv_s1) begin
					state_q <= ST_OUT;
					out_valid_q <= 1'b1;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign q_pop = (state_q == ST_LOAD) || (state_q == ST_OUT);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		rstep_q <= step_q;
		rvin_q <= vin;
		rweight_q <= weight;
		prod_s1 <= mop_a * mop_b;
		pstep_s1 <= rstep_q;
	end

	// Accumulate at s2
	logic signed [63:0] rnd;
	always_comb rnd = prod_s1 + 64'sd32768;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_item.op == OP_VERTEX && !out_valid_q) begin
			for (int c = 0; c < 6; c++) begin
				wacc_q[c] <= '0;
				xacc_q[c] <= '0;
			end
		end else if (state_q == ST_RUN && step_q == 6'd0) begin
			// start of an influence: earlier transform sums are already weighted
			for (int c = 0; c < 6; c++) xacc_q[c] <= '0;
		end
		if (pv_s1) begin
			if (pstep_s1 < 6'd18)
				xacc_q[comp_of(pstep_s1)] <= xacc_q[comp_of(pstep_s1)] + 49'(rnd >>> 16);
			else if (pstep_s1 >= StepXEnd)
				wacc_q[3'(pstep_s1 - StepXEnd)] <= wacc_q[3'(pstep_s1 - StepXEnd)]
					+ 49'((prod_s1 + 64'sd16384) >>> 15);
		end
		// translation word lands straight from the memory read register
		if (rv_q && rstep_q >= 6'd18 && rstep_q < StepXEnd)
			xacc_q[3'(rstep_q - 6'd18)] <= xacc_q[3'(rstep_q - 6'd18)] + 49'(rd_data_q);
		for (int c = 0; c < 6; c++) xsat_q[c] <= sat32(xacc_q[c]);
		if (state_q == ST_DRAIN && !rv_q && !pv_s1) begin
			for (int c = 0; c < 6; c++) res_q[c] <= sat32(wacc_q[c]);
			mesh_end_q <= q_item.last_vertex;
		end
	end
endmodule

FILE: hdl/linear_blend_skinning_top.sv
// Four-bone skinning top level: front end queue and back end sequencer.
// Vertices are handled one at a time: the back end skips influences that are not live,
// runs each live one through the single shared multiplier and the one palette read
// port, and pops the vertex only after draining. A held result blocks vertices.
// Reset clears control and bone_count; the palette is undefined until written.
`timescale 1ns / 1ps
module linear_blend_skinning_top #(
	parameter int MAX_BONES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [9:0]  entry_addr,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	input  logic [31:0] bone_ids,
	input  logic [63:0] bone_weights,
	input  logic        last_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] skinned_pos_x,
	output logic signed [31:0] skinned_pos_y,
	output logic signed [31:0] skinned_pos_z,
	output logic signed [31:0] skinned_nrm_x,
	output logic signed [31:0] skinned_nrm_y,
	output logic signed [31:0] skinned_nrm_z,
	output logic        mesh_end
);
	import lbs_pkg::*;

	item_t in_item, q_item;
	logic q_valid, q_pop;
	logic signed [31:0] res [6];

	always_comb begin
		in_item = '0;
		in_item.op = op;
		in_item.entry_addr = entry_addr;
		in_item.entry_value = entry_value;
		in_item.pos_x = pos_x;
		in_item.pos_y = pos_y;
		in_item.pos_z = pos_z;
		in_item.nrm_x = nrm_x;
		in_item.nrm_y = nrm_y;
		in_item.nrm_z = nrm_z;
		in_item.bone_ids = bone_ids;
		in_item.bone_weights = bone_weights;
		in_item.last_vertex = last_vertex;
	end

	lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_item,
		.q_valid, .q_pop, .q_item
	);

	lbs_back #(.MAX_BONES(MAX_BONES)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
		.res_q(res), .mesh_end_q(mesh_end)
	);

	assign skinned_pos_x = res[0];
	assign skinned_pos_y = res[1];
	assign skinned_pos_z = res[2];
	assign skinned_nrm_x = res[3];
	assign skinned_nrm_y = res[4];
	assign skinned_nrm_z = res[5];
endmodule

FILE: tb/sv/tb_linear_blend_skinning_top.sv
// Testbench for linear_blend_skinning_top: palette loads and vertex items checked
// against an in-bench Q16.16 skinning predictor. Depends on lbs_pkg and the top level.
`timescale 1ns / 1ps
module tb_linear_blend_skinning_top;
	import lbs_pkg::*;

	localparam int MaxBones = 64;
	localparam int PaletteWords = MaxBones * WordsPerBone;
	localparam int DrainCycles = 200;

	typedef struct {
		logic               op;
		logic [9:0]         addr;
		logic signed [31:0] value;
		logic signed [31:0] p [3];
		logic signed [31:0] n [3];
		logic [31:0]        ids;
		logic [63:0]        wts;
		logic               last;
	} skin_item_t;

	typedef struct {
		logic signed [31:0] p [3];
		logic signed [31:0] n [3];
		logic               last;
	} skinned_vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_LOAD;
	logic [9:0] entry_addr = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
	logic [31:0] bone_ids = '0;
	logic [63:0] bone_weights = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] skinned_pos_x, skinned_pos_y, skinned_pos_z;
	logic signed [31:0] skinned_nrm_x, skinned_nrm_y, skinned_nrm_z;
	logic mesh_end;

	skin_item_t pending_items [$];
	skinned_vertex_t expected_vertices [$];
	skin_item_t cur_item;
	logic signed [31:0] palette_copy [PaletteWords];
	bit word_written [PaletteWords];
	int bone_count_copy = 0;
	int gen_limit = 0;
	int send_gap = 0;
	int recv_hold = 0;
	bit no_idle = 0;
	bit long_hold_req = 0;
	int error_count = 0;

	linear_blend_skinning_top #(.MAX_BONES(MaxBones)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .entry_addr(entry_addr),
		.entry_value(entry_value), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z), .bone_ids(bone_ids),
		.bone_weights(bone_weights), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.skinned_pos_x(skinned_pos_x), .skinned_pos_y(skinned_pos_y),
		.skinned_pos_z(skinned_pos_z), .skinned_nrm_x(skinned_nrm_x),
		.skinned_nrm_y(skinned_nrm_y), .skinned_nrm_z(skinned_nrm_z),
		.mesh_end(mesh_end)
	);

	always #6 clk = ~clk;

	function automatic longint sat32_l(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one column of the row-vector transform, saturated
	function automatic longint xform_col(logic signed [31:0] v [3], int bone, int col,
			bit translate);
		longint acc;
		acc = 0;
		for (int r = 0; r < 3; r++)
			acc += (longint'(v[r]) * longint'(palette_copy[bone * WordsPerBone + r * 3 + col])
				+ 64'sd32768) >>> 16;
		if (translate)
			acc += longint'(palette_copy[bone * WordsPerBone + 9 + col]);
		return sat32_l(acc);
	endfunction

	function automatic void apply_skin_item(skin_item_t it);
		longint acc_p [3];
		longint acc_n [3];
		longint w;
		int id;
		int limit;
		skinned_vertex_t res;
		if (it.op == OP_LOAD) begin
			if (it.addr < PaletteWords)
				palette_copy[it.addr] = it.value;
			return;
		end
		limit = bone_count_copy > MaxBones ? MaxBones : bone_count_copy;
		for (int c = 0; c < 3; c++) begin
			acc_p[c] = 0;
			acc_n[c] = 0;
		end
		for (int i = 0; i < Influences; i++) begin
			id = int'(it.ids[8 * i +: 8]);
			w = longint'(it.wts[16 * i +: 16]);
			if (w == 0 || id >= limit)
				continue;
			for (int c = 0; c < 3; c++) begin
				acc_p[c] += (xform_col(it.p, id, c, 1) * w + 64'sd16384) >>> 15;
				acc_n[c] += (xform_col(it.n, id, c, 0) * w + 64'sd16384) >>> 15;
			end
		end
		for (int c = 0; c < 3; c++) begin
			res.p[c] = 32'(sat32_l(acc_p[c]));
			res.n[c] = 32'(sat32_l(acc_n[c]));
		end
		res.last = it.last;
		expected_vertices.insert(expected_vertices.size(), res);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (no_idle || r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: hold the item while stalled, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				apply_skin_item(cur_item);
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				op <= cur_item.op;
				entry_addr <= cur_item.addr;
				entry_value <= cur_item.value;
				pos_x <= cur_item.p[0];
				pos_y <= cur_item.p[1];
				pos_z <= cur_item.p[2];
				nrm_x <= cur_item.n[0];
				nrm_y <= cur_item.n[1];
				nrm_z <= cur_item.n[2];
				bone_ids <= cur_item.ids;
				bone_weights <= cur_item.wts;
				last_vertex <= cur_item.last;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	// monitor: check accepted results, drive random stall and the long hold
	always @(posedge clk or negedge arst_n) begin
		skinned_vertex_t ev;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual pos %h %h %h",
						$time, skinned_pos_x, skinned_pos_y, skinned_pos_z);
					error_count++;
				end else begin
					ev = expected_vertices.pop_front();
					check_field("skinned_pos_x", ev.p[0], skinned_pos_x);
					check_field("skinned_pos_y", ev.p[1], skinned_pos_y);
					check_field("skinned_pos_z", ev.p[2], skinned_pos_z);
					check_field("skinned_nrm_x", ev.n[0], skinned_nrm_x);
					check_field("skinned_nrm_y", ev.n[1], skinned_nrm_y);
					check_field("skinned_nrm_z", ev.n[2], skinned_nrm_z);
					check_field("mesh_end", 32'(ev.last), 32'(mesh_end));
				end
			end
			if (long_hold_req) begin
				long_hold_req = 0;
				recv_hold = 2000;
				out_stall <= 1'b1;
			end else if (recv_hold > 0) begin
				recv_hold--;
				out_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 9) >= 6) begin
				recv_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3, 4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_matrix_word();
		if ($urandom_range(0, 4) == 0) return rand_word();
		return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
	endfunction

	function automatic bit bone_ready(int b);
		for (int k = 0; k < WordsPerBone; k++)
			if (!word_written[b * WordsPerBone + k]) return 0;
		return 1;
	endfunction

	task automatic queue_load(int addr, logic signed [31:0] value);
		skin_item_t it;
		it.op = OP_LOAD;
		it.addr = 10'(addr);
		it.value = value;
		for (int c = 0; c < 3; c++) begin
			it.p[c] = $urandom;
			it.n[c] = $urandom;
		end
		it.ids = $urandom;
		it.wts = {$urandom, $urandom};
		it.last = 1'($urandom_range(0, 1));
		if (addr < PaletteWords)
			word_written[addr] = 1;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_vertex(logic [31:0] ids, logic [63:0] wts, bit last, bit extreme);
		skin_item_t it;
		it.op = OP_VERTEX;
		it.addr = 10'($urandom);
		it.value = $urandom;
		for (int c = 0; c < 3; c++) begin
			it.p[c] = extreme ? (c[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000) : rand_word();
			it.n[c] = extreme ? (c[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : rand_word();
		end
		it.ids = ids;
		it.wts = wts;
		it.last = last;
		pending_items.insert(pending_items.size(), it);
	endtask

	// live weights point at fully loaded bones below the limit, or at times at ids at or above it
	task automatic queue_random_vertex();
		int live [$];
		logic [31:0] ids;
		logic [63:0] wts;
		logic [15:0] w;
		for (int b = 0; b < gen_limit; b++)
			if (bone_ready(b)) live.insert(live.size(), b);
		for (int i = 0; i < Influences; i++) begin
			case ($urandom_range(0, 5))
				0: w = 16'h0;
				1: w = 16'h8000;
				2: w = 16'hFFFF;
				default: w = 16'($urandom_range(1, 16'hFFFF));
			endcase
			if (w == 0)
				ids[8 * i +: 8] = 8'($urandom_range(0, 255));
			else if (live.size() == 0 || $urandom_range(0, 4) == 0)
				ids[8 * i +: 8] = 8'($urandom_range(gen_limit, 255));
			else
				ids[8 * i +: 8] = 8'(live[$urandom_range(0, live.size() - 1)]);
			wts[16 * i +: 16] = w;
		end
		queue_vertex(ids, wts, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
	endtask

	task automatic queue_bone(int b);
		for (int k = 0; k < WordsPerBone; k++)
			queue_load(b * WordsPerBone + k, rand_matrix_word());
	endtask

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !in_valid && expected_vertices.size() == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_bone_count(int v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		bone_count_copy = v;
		gen_limit = v > MaxBones ? MaxBones : v;
	endtask

	initial begin
		int phase_counts [6] = '{127, 0, 5, 64, 1, 40};
		int start_size;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		write_bone_count(64);
		// bone 0: identity with translation, bone 63: extreme words
		for (int k = 0; k < WordsPerBone; k++)
			queue_load(k, (k < 9 && k % 4 == 0) ? 32'sh1_0000 : (k >= 9 ? 32'sh5_8000 : 0));
		for (int k = 0; k < WordsPerBone; k++)
			queue_load(63 * WordsPerBone + k, k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
		queue_load(1023, 32'sh1234_5678);
		queue_vertex(32'h0, 64'h0, 0, 0);
		queue_vertex(32'h0, 64'h8000, 0, 0);
		queue_vertex(32'h3F, 64'hFFFF, 0, 1);
		queue_vertex(32'hC8, 64'h8000, 0, 0);
		queue_vertex(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
		queue_vertex(32'h3F00_3F00, 64'h0001_8000_FFFF_4000, 1, 0);
		wait_idle();

		foreach (phase_counts[ph]) begin
			write_bone_count(phase_counts[ph]);
			no_idle = (ph == 2);
			if (ph == 3) begin
				for (int v = 0; v < 30; v++)
					queue_random_vertex();
				long_hold_req = 1;
			end
			start_size = 0;
			while (start_size < 70) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						queue_bone($urandom_range(0, MaxBones - 1));
						start_size += WordsPerBone;
					end
					2: begin
						if ($urandom_range(0, 3) == 0)
							queue_load($urandom_range(PaletteWords, 1023), rand_word());
						else
							queue_load($urandom_range(0, PaletteWords - 1), rand_matrix_word());
						start_size++;
					end
					default: begin
						queue_random_vertex();
						start_size++;
					end
				endcase
			end
		end
		no_idle = 0;
		wait_idle();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule
